### src/scrolling_text_row_buffer_assert.svh
// Assertion macros for the scrolling text row buffer.
// Used by the top level; no other dependencies.
`ifndef SCROLLING_TEXT_ROW_BUFFER_ASSERT_SVH
`define SCROLLING_TEXT_ROW_BUFFER_ASSERT_SVH

// same-cycle implication
`define STXT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication
`define STXT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

### src/stxt_pkg.sv
// Shared types and constants of the scrolling text row buffer.
// No dependencies; imported by the control block and the top level.
package stxt_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS    = 2'd1;

   localparam logic [15:0] CHAR_NEWLINE = 16'd10;

   typedef enum logic [1:0] {
      ACT_PUSH   = 2'd0,
      ACT_ROTATE = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   typedef struct packed {
      action_type  action;
      logic [15:0] char_in;
      logic [4:0]  read_row;
      logic [5:0]  read_col;
   } req_type;

   typedef struct packed {
      logic [15:0] read_char;
      logic        full_res;
   } rsp_type;

   typedef struct packed {
      logic char_we;
      logic len_we;
      logic rd_ok;
      logic full_next;
   } ctrl_stat_type;

endpackage

### src/stxt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module stxt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/stxt_ctrl.sv
// Layout registers, write point, full flag and per-row valid bits.
// Depends on stxt_pkg; drives the character and row-length RAM ports.
module stxt_ctrl #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 32,
   localparam int RW  = $clog2(MAX_ROWS),
   localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
   localparam int CNW = $clog2(MAX_COLS + 1),
   localparam int RNW = $clog2(MAX_ROWS + 1),
   localparam int AW  = $clog2(MAX_ROWS * MAX_COLS)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  stxt_pkg::req_type               req,
   input  logic                            csr_we,
   input  logic [stxt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [stxt_pkg::CSR_DATA_W-1:0] csr_wdata,
   output stxt_pkg::ctrl_stat_type         stat,
   output logic [AW-1:0]                   char_waddr,
   output logic [AW-1:0]                   char_raddr,
   output logic [15:0]                     char_wdata,
   output logic [RW-1:0]                   len_waddr,
   output logic [RW-1:0]                   len_raddr,
   output logic [CNW-1:0]                  len_wdata
);
   import stxt_pkg::*;

   localparam int COLS_RST = (MAX_COLS < 64) ? MAX_COLS : 64;
   localparam int ROWS_RST = (MAX_ROWS < 32) ? MAX_ROWS : 32;

   logic [CNW-1:0]      cols_ff, cols_in;
   logic [RNW-1:0]      rows_ff, rows_in;
   logic [RW-1:0]       top_ff, top_in;
   logic [RW-1:0]       wrow_ff, wrow_in;
   logic [CNW-1:0]      cur_ff, cur_in;
   logic                full_ff, full_in;
   logic [MAX_ROWS-1:0] vld_ff, vld_in;

   logic [RNW-1:0] rows_m1;
   logic [RW-1:0]  bottom;
   logic [RW:0]    wrow_p1;
   logic [RW:0]    top_p1;
   logic [RW-1:0]  next_wrow;
   logic [RW-1:0]  next_top;
   logic [RW:0]    psum;
   logic [RW-1:0]  phys;
   logic [CW-1:0]  rcol;
   logic [CNW-1:0] cur_p1;
   logic           rd_in_range;

   assign rows_m1   = rows_ff - RNW'(1);
   assign bottom    = (top_ff == '0) ? rows_m1[RW-1:0] : top_ff - RW'(1);
   assign wrow_p1   = {1'b0, wrow_ff} + (RW+1)'(1);
   assign top_p1    = {1'b0, top_ff} + (RW+1)'(1);
   assign next_wrow = (wrow_p1 >= (RW+1)'(rows_ff)) ? '0 : wrow_p1[RW-1:0];
   assign next_top  = (top_p1 >= (RW+1)'(rows_ff)) ? '0 : top_p1[RW-1:0];
   assign cur_p1    = cur_ff + CNW'(1);

   assign rd_in_range = (32'(req.read_row) < 32'(rows_ff)) &&
                        (32'(req.read_col) < 32'(cols_ff));
   assign psum = {1'b0, top_ff} + (RW+1)'(req.read_row);
   assign phys = (psum >= (RW+1)'(rows_ff)) ? RW'(psum - (RW+1)'(rows_ff)) : psum[RW-1:0];
   assign rcol = CW'(req.read_col);

   assign char_waddr = AW'(32'(wrow_ff) * MAX_COLS + 32'(cur_ff[CW-1:0]));
   assign char_raddr = AW'(32'(phys) * MAX_COLS + 32'(rcol));
   assign char_wdata = req.char_in;
   assign len_waddr  = wrow_ff;
   assign len_raddr  = phys;
   assign len_wdata  = cur_p1;

   always_comb begin
      cols_in       = cols_ff;
      rows_in       = rows_ff;
      top_in        = top_ff;
      wrow_in       = wrow_ff;
      cur_in        = cur_ff;
      full_in       = full_ff;
      vld_in        = vld_ff;
      stat.char_we  = 1'b0;
      stat.len_we   = 1'b0;
      stat.rd_ok    = rd_in_range && vld_ff[phys];
      if (csr_we) begin
         if (csr_index == CSR_COLUMNS) begin
            cols_in = (32'(csr_wdata) > MAX_COLS) ? CNW'(MAX_COLS) : CNW'(csr_wdata);
            top_in  = '0;
            wrow_in = '0;
            cur_in  = '0;
            full_in = 1'b0;
            vld_in  = '0;
         end else if (csr_index == CSR_ROWS && csr_wdata >= CSR_DATA_W'(2)) begin
            rows_in = (32'(csr_wdata) > MAX_ROWS) ? RNW'(MAX_ROWS) : RNW'(csr_wdata);
            top_in  = '0;
            wrow_in = '0;
            cur_in  = '0;
            full_in = 1'b0;
            vld_in  = '0;
         end
      end else if (accept) begin
         unique case (req.action)
            ACT_PUSH: begin
               if (!full_ff && req.char_in != '0) begin
                  if (req.char_in == CHAR_NEWLINE) begin
                     if (wrow_ff == bottom) begin
                        full_in = 1'b1;
                     end else begin
                        wrow_in = next_wrow;
                        cur_in  = '0;
                     end
                  end else if (cur_ff < cols_ff) begin
                     stat.char_we     = 1'b1;
                     stat.len_we      = 1'b1;
                     vld_in[wrow_ff]  = 1'b1;
                     cur_in           = cur_p1;
                     if (cur_p1 >= cols_ff) begin
                        if (wrow_ff == bottom) begin
                           full_in = 1'b1;
                        end else begin
                           wrow_in = next_wrow;
                           cur_in  = '0;
                        end
                     end
                  end
               end
            end
            ACT_ROTATE: begin
               top_in         = next_top;
               vld_in[top_ff] = 1'b0;
               wrow_in        = top_ff;
               cur_in         = '0;
               full_in        = 1'b0;
            end
            ACT_CLEAR: begin
               vld_in  = '0;
               wrow_in = top_ff;
               cur_in  = '0;
               full_in = 1'b0;
            end
            ACT_READ: begin
            end
         endcase
      end
      stat.full_next = full_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= CNW'(COLS_RST);
         rows_ff <= RNW'(ROWS_RST);
         top_ff  <= '0;
         wrow_ff <= '0;
         cur_ff  <= '0;
         full_ff <= 1'b0;
         vld_ff  <= '0;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
         top_ff  <= top_in;
         wrow_ff <= wrow_in;
         cur_ff  <= cur_in;
         full_ff <= full_in;
         vld_ff  <= vld_in;
      end
   end

endmodule

### src/scrolling_text_row_buffer.sv
// Top level of the scrolling text row buffer: handshake, read sequencing, result register.
// Depends on stxt_pkg, stxt_ram, stxt_ctrl and scrolling_text_row_buffer_assert.svh.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data  (stxt_pkg::req_type)
//   rsp      out        rsp_valid / rsp_ready  rsp_data  (stxt_pkg::rsp_type)
//   csr      in         csr_we                 csr_index, csr_wdata
//
// Push, rotate and clear transactions go straight to the result register; a read first passes
// through the registered read of the character RAM and the row-length RAM (state ST_READ).
// Reset clears the per-row valid bits at once; no clearing pass runs.
// Rotate and clear empty rows through those valid bits, with no clearing pass.
// A result waiting on rsp that rsp_ready does not take stalls req, as does state ST_READ.
`include "scrolling_text_row_buffer_assert.svh"
module scrolling_text_row_buffer #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  stxt_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output stxt_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [stxt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [stxt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import stxt_pkg::*;

   localparam int RW  = $clog2(MAX_ROWS);
   localparam int CNW = $clog2(MAX_COLS + 1);
   localparam int AW  = $clog2(MAX_ROWS * MAX_COLS);

   state_type     state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;
   logic          rd_ok_ff;
   logic [CNW-1:0] rcol_ff;

   logic           accept;
   ctrl_stat_type  stat;
   logic [AW-1:0]  char_waddr;
   logic [AW-1:0]  char_raddr;
   logic [15:0]    char_wdata;
   logic [15:0]    char_rdata;
   logic [RW-1:0]  len_waddr;
   logic [RW-1:0]  len_raddr;
   logic [CNW-1:0] len_wdata;
   logic [CNW-1:0] len_rdata;

   stxt_ctrl #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .stat       (stat),
      .char_waddr (char_waddr),
      .char_raddr (char_raddr),
      .char_wdata (char_wdata),
      .len_waddr  (len_waddr),
      .len_raddr  (len_raddr),
      .len_wdata  (len_wdata)
   );

   stxt_ram #(
      .WIDTH(16),
      .DEPTH(MAX_ROWS * MAX_COLS)
   ) u_char_ram (
      .clock (clock),
      .we    (stat.char_we),
      .waddr (char_waddr),
      .wdata (char_wdata),
      .raddr (char_raddr),
      .rdata (char_rdata)
   );

   stxt_ram #(
      .WIDTH(CNW),
      .DEPTH(MAX_ROWS)
   ) u_len_ram (
      .clock (clock),
      .we    (stat.len_we),
      .waddr (len_waddr),
      .wdata (len_wdata),
      .raddr (len_raddr),
      .rdata (len_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.action == ACT_READ) begin
                  state_in = ST_READ;
               end else begin
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.read_char = '0;
                  rsp_data_in.full_res  = stat.full_next;
               end
            end
         end
         ST_READ: begin
            state_in              = ST_IDLE;
            rsp_valid_in          = 1'b1;
            rsp_data_in.read_char = (rd_ok_ff && rcol_ff < len_rdata) ? char_rdata : '0;
            rsp_data_in.full_res  = stat.full_next;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         rd_ok_ff <= stat.rd_ok;
         rcol_ff  <= CNW'(req_data.read_col);
      end
   end

   `STXT_ASSERT_IMP(a_no_accept_in_read, clock, reset, state_ff == ST_READ, !req_ready)
   `STXT_ASSERT_NXT(a_read_goes_busy, clock, reset, accept && req_data.action == ACT_READ, state_ff == ST_READ && !rsp_valid_ff)
   `STXT_ASSERT_NXT(a_read_returns, clock, reset, state_ff == ST_READ, state_ff == ST_IDLE && rsp_valid_ff)
   `STXT_ASSERT_NXT(a_other_returns, clock, reset, accept && req_data.action != ACT_READ, rsp_valid_ff)

endmodule

### dv/tb_scrolling_text_row_buffer.sv
// Self-checking testbench for scrolling_text_row_buffer: random bursts of push, rotate,
// clear and read transactions over several row and column settings, checked by a predictor.
// Depends on stxt_pkg and the RTL of scrolling_text_row_buffer only.
module tb_scrolling_text_row_buffer;
   import stxt_pkg::*;

   localparam int TEXT_COLS = 64;
   localparam int TEXT_ROWS = 32;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASE_ITEMS = 260;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   req_type pending_req[$];
   rsp_type expected_rsp[$];

   logic [15:0] text_store [0:TEXT_ROWS*TEXT_COLS-1];
   int unsigned top_line;
   int unsigned cursor_line;
   int unsigned cursor_col;
   logic        buffer_full;
   int unsigned line_width;
   int unsigned line_count;

   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;
   logic        req_taken = 1'b0;
   int unsigned gap_left = 0;
   int unsigned burst_left = 0;
   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;

   scrolling_text_row_buffer #(
      .MAX_COLS(TEXT_COLS),
      .MAX_ROWS(TEXT_ROWS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic int unsigned following_line(int unsigned r);
      return (r + 1 >= line_count) ? 0 : r + 1;
   endfunction

   function automatic int unsigned last_line();
      return (top_line + line_count - 1) % line_count;
   endfunction

   function automatic void advance_line();
      if (cursor_line == last_line()) begin
         buffer_full = 1'b1;
      end else begin
         cursor_line = following_line(cursor_line);
         cursor_col = 0;
      end
   endfunction

   function automatic void clear_text();
      for (int i = 0; i < TEXT_ROWS*TEXT_COLS; i++) begin
         text_store[i] = '0;
      end
      cursor_line = top_line;
      cursor_col = 0;
      buffer_full = 1'b0;
   endfunction

   function automatic void restore_layout();
      top_line = 0;
      clear_text();
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      if (idx == CSR_COLUMNS) begin
         line_width = (32'(val) > TEXT_COLS) ? TEXT_COLS : 32'(val);
         restore_layout();
      end else if (idx == CSR_ROWS && val >= 2) begin
         line_count = (32'(val) > TEXT_ROWS) ? TEXT_ROWS : 32'(val);
         restore_layout();
      end
   endfunction

   function automatic rsp_type predict_text_step(req_type t);
      rsp_type r;
      int unsigned old_top;
      int unsigned phys;
      r.read_char = '0;
      case (t.action)
         ACT_PUSH: begin
            if (!buffer_full && t.char_in != 0) begin
               if (t.char_in == CHAR_NEWLINE) begin
                  advance_line();
               end else if (cursor_col < line_width) begin
                  text_store[cursor_line*TEXT_COLS + cursor_col] = t.char_in;
                  cursor_col++;
                  if (cursor_col >= line_width) begin
                     advance_line();
                  end
               end
            end
         end
         ACT_ROTATE: begin
            old_top = top_line;
            top_line = following_line(old_top);
            for (int i = 0; i < TEXT_COLS; i++) begin
               text_store[old_top*TEXT_COLS + i] = '0;
            end
            cursor_line = old_top;
            cursor_col = 0;
            buffer_full = 1'b0;
         end
         ACT_CLEAR: begin
            clear_text();
         end
         default: begin
            if (t.read_row < line_count && t.read_col < line_width) begin
               phys = (top_line + t.read_row) % line_count;
               r.read_char = text_store[phys*TEXT_COLS + t.read_col];
            end
         end
      endcase
      r.full_res = buffer_full;
      return r;
   endfunction

   function automatic req_type make_op(action_type a);
      req_type t;
      t.action = a;
      t.char_in = 16'($urandom_range(0, 65535));
      t.read_row = 5'($urandom_range(0, 31));
      t.read_col = 6'($urandom_range(0, 63));
      return t;
   endfunction

   function automatic req_type make_push(logic [15:0] ch);
      req_type t;
      t = make_op(ACT_PUSH);
      t.char_in = ch;
      return t;
   endfunction

   function automatic req_type make_read(int unsigned row, int unsigned col);
      req_type t;
      t = make_op(ACT_READ);
      t.read_row = 5'(row);
      t.read_col = 6'(col);
      return t;
   endfunction

   function automatic req_type random_req();
      int unsigned pick;
      int unsigned flavor;
      req_type t;
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         flavor = $urandom_range(0, 99);
         if (flavor < 12) begin
            t = make_push(CHAR_NEWLINE);
         end else if (flavor < 15) begin
            t = make_push(16'd0);
         end else if (flavor < 25) begin
            t = make_push(16'($urandom_range(0, 65535)));
         end else begin
            t = make_push(16'($urandom_range(32, 126)));
         end
      end else if (pick < 63) begin
         t = make_op(ACT_ROTATE);
      end else if (pick < 65) begin
         t = make_op(ACT_CLEAR);
      end else if ($urandom_range(0, 9) < 8 && line_width != 0) begin
         t = make_read($urandom_range(0, line_count - 1), $urandom_range(0, line_width - 1));
      end else begin
         t = make_op(ACT_READ);
      end
      return t;
   endfunction

   task automatic add_random(int unsigned n);
      repeat (n) pending_req.push_back(random_req());
   endtask

   task automatic wait_idle(int unsigned extra);
      while (pending_req.size() != 0 || expected_rsp.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      repeat (extra) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic note_mismatch(string field, int unsigned want, int unsigned got);
      mismatch_count++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, field, want, got);
   endtask

   // driver: bursts of transactions separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (pending_req.size() != 0) begin
            req_data <= pending_req.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 32);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: rsp_ready follows one of four stall modes, picked anew at random
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(8, 64);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= (stall_left % 4 == 0);
         default: rsp_ready <= (stall_left < 4);
      endcase
   end

   // monitor: predict on each accepted request, check each accepted result
   always @(posedge clock) begin
      rsp_type want;
      cycle_count++;
      req_taken = req_valid && req_ready;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else if (reset) begin
         line_width = TEXT_COLS;
         line_count = TEXT_ROWS;
         restore_layout();
         req_taken = 1'b0;
      end else begin
         if (csr_we) begin
            apply_csr(csr_index, csr_wdata);
         end
         if (req_valid && req_ready) begin
            expected_rsp.push_back(predict_text_step(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               mismatch_count++;
               $display("%0t unexpected transaction: expected none actual %0h/%0b",
                        $time, rsp_data.read_char, rsp_data.full_res);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.read_char !== want.read_char) begin
                  note_mismatch("read_char", 32'(want.read_char), 32'(rsp_data.read_char));
               end
               if (rsp_data.full_res !== want.full_res) begin
                  note_mismatch("full_res", 32'(want.full_res), 32'(rsp_data.full_res));
               end
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      pending_req.push_back(make_push(16'h0041));
      pending_req.push_back(make_push(16'h0000));
      pending_req.push_back(make_push(16'hFFFF));
      pending_req.push_back(make_push(16'h8000));
      pending_req.push_back(make_push(16'h7FFF));
      pending_req.push_back(make_push(CHAR_NEWLINE));
      pending_req.push_back(make_push(16'h0001));
      pending_req.push_back(make_read(0, 0));
      pending_req.push_back(make_read(0, 1));
      pending_req.push_back(make_read(0, 2));
      pending_req.push_back(make_read(0, 3));
      pending_req.push_back(make_read(1, 0));
      pending_req.push_back(make_read(1, 1));
      pending_req.push_back(make_read(31, 63));
      pending_req.push_back(make_op(ACT_ROTATE));
      pending_req.push_back(make_read(0, 0));
      pending_req.push_back(make_read(31, 0));
      pending_req.push_back(make_push(16'h0042));
      pending_req.push_back(make_read(31, 0));
      pending_req.push_back(make_op(ACT_CLEAR));
      pending_req.push_back(make_read(0, 0));
      pending_req.push_back(make_push(16'h0043));
      pending_req.push_back(make_read(0, 0));
      add_random(PHASE_ITEMS - 23);

      wait_idle(4);
      csr_write(CSR_COLUMNS, 7'd1);
      csr_write(CSR_ROWS, 7'd2);
      add_random(PHASE_ITEMS);

      wait_idle(4);
      csr_write(CSR_COLUMNS, 7'd127);
      csr_write(CSR_ROWS, 7'd1);
      csr_write(CSR_ROWS, 7'd0);
      add_random(PHASE_ITEMS);

      wait_idle(4);
      csr_write(CSR_COLUMNS, 7'd0);
      csr_write(CSR_ROWS, 7'd5);
      add_random(PHASE_ITEMS);

      wait_idle(4);
      csr_write(CSR_COLUMNS, 7'd7);
      csr_write(CSR_ROWS, 7'd127);
      csr_write(CSR_UNMAPPED_LO, 7'd127);
      csr_write(CSR_UNMAPPED_HI, 7'd0);
      add_random(PHASE_ITEMS);

      wait_idle(4);
      csr_write(CSR_COLUMNS, 7'd3);
      csr_write(CSR_ROWS, 7'd4);
      add_random(PHASE_ITEMS);

      wait_idle(4);
      csr_write(CSR_COLUMNS, 7'd64);
      csr_write(CSR_ROWS, 7'd32);
      add_random(PHASE_ITEMS);

      wait_idle(4);
      csr_write(CSR_ROWS, 7'd3);
      csr_write(CSR_COLUMNS, 7'd2);
      add_random(PHASE_ITEMS);

      wait_idle(10);
      if (mismatch_count == 0 && expected_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
